// File: hw/rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg : shared types and constants for the move shape decomposer
// Field widths, move kinds, divider geometry and the stage payload structs.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int SpdW   = 24;
    localparam int TrackW = 20;
    localparam int AmtW   = 32;
    localparam int UnitW  = 16;
    localparam int DurW   = 32;
    localparam int TravW  = 32;

    // divider geometry: numerator covers stop amount times track width
    localparam int DivNW  = 52;
    localparam int DivDW  = 25;
    localparam int DivQW  = 32;
    localparam int DivLat = DivQW + 2;

    localparam logic [UnitW-1:0] UNIT_ONE = 16'd16384;
    localparam logic [DivDW-1:0] MS_PER_S = 25'd1000;

    typedef enum logic [1:0] {
        KIND_STOP  = 2'd0,
        KIND_TIME  = 2'd1,
        KIND_DIST  = 2'd2,
        KIND_ANGLE = 2'd3
    } t_kind;

    // per-item control carried alongside the dividers
    typedef struct packed {
        logic                   bad;
        t_kind                  kind;
        logic signed [SpdW-1:0] vl;
        logic signed [SpdW-1:0] vr;
        logic [SpdW-1:0]        peak;
        logic                   dom_left;
    } t_side;

    typedef struct packed {
        logic                    distance_target;
        logic                    time_budget;
        logic                    valid_res;
        logic [TravW-1:0]        travel_right;
        logic [TravW-1:0]        travel_left;
        logic [DurW-1:0]         duration;
        logic [SpdW-1:0]         cruise_speed;
        logic [UnitW-1:0]        unit_right;
        logic [UnitW-1:0]        unit_left;
    } t_res;

endpackage

// File: hw/rtl/msd_div.sv
// ----------------------------------------------------------------------------
// msd_div : pipelined restoring divider with round-to-nearest
// One quotient bit per stage; saturates the quotient at all ones.
// ----------------------------------------------------------------------------
module msd_div #(
    parameter int NW = 52,
    parameter int DW = 25,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [0:QW];
    logic [QW-1:0] r_low [0:QW];
    logic [DW-1:0] r_d   [0:QW];
    logic          r_ovf [0:QW];
    logic [QW-1:0] r_quo;

    logic [DW:0]   w_t  [0:QW-1];
    logic          w_ge [0:QW-1];

    logic          w_rnd;
    logic [QW:0]   w_sum;

    // entry: quotient would not fit when the high part already reaches d
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num[NW-1:QW]);
            r_low[0] <= i_num[QW-1:0];
            r_d[0]   <= i_den;
            r_ovf[0] <= {{DW{1'b0}}, i_num[NW-1:QW]} >= {{(NW-QW){1'b0}}, i_den};
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_step
        assign w_t[i]  = {r_rem[i], r_low[i][QW-1]};
        assign w_ge[i] = w_t[i] >= {1'b0, r_d[i]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= w_ge[i] ? DW'(w_t[i] - {1'b0, r_d[i]}) : w_t[i][DW-1:0];
                r_low[i+1] <= {r_low[i][QW-2:0], w_ge[i]};
                r_d[i+1]   <= r_d[i];
                r_ovf[i+1] <= r_ovf[i];
            end
        end
    end

    // round up when twice the remainder reaches the divisor
    assign w_rnd = {r_rem[QW], 1'b0} >= {1'b0, r_d[QW]};
    assign w_sum = {1'b0, r_low[QW]} + {{QW{1'b0}}, w_rnd};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= (r_ovf[QW] || w_sum[QW]) ? '1 : w_sum[QW-1:0];
        end
    end

    assign o_quo = r_quo;

endmodule

// File: hw/rtl/msd_skid.sv
// ----------------------------------------------------------------------------
// msd_skid : output register with skid stage
// Parts the pipeline from the downstream handshake; ready is registered.
// ----------------------------------------------------------------------------
module msd_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  msd_pkg::t_res i_data,
    output logic          o_ready,
    output logic          o_valid,
    output msd_pkg::t_res o_data,
    input  logic          i_ready
);

    logic          r_ob_vld;
    logic          r_sk_vld;
    msd_pkg::t_res r_ob;
    msd_pkg::t_res r_sk;
    logic          w_push;
    logic          w_pop;

    assign o_ready = !r_sk_vld;
    assign w_push  = i_valid && !r_sk_vld;
    assign w_pop   = r_ob_vld && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_vld <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (w_pop) begin
                r_sk_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_ob_vld || w_pop) begin
                r_ob_vld <= 1'b1;
            end else begin
                r_sk_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_ob_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (w_pop) begin
                r_ob <= r_sk;
            end
        end else if (w_push) begin
            if (!r_ob_vld || w_pop) begin
                r_ob <= i_data;
            end else begin
                r_sk <= i_data;
            end
        end
    end

    assign o_valid = r_ob_vld;
    assign o_data  = r_ob;

endmodule

// File: hw/rtl/move_shape_decompose.sv
// ----------------------------------------------------------------------------
// move_shape_decompose : differential-drive move shaper
// Turns one move command into unit wheel speeds, cruise speed, duration and
// per-wheel travel, in a deep pipeline with bit-per-stage dividers.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------
//  s        | in        | i_s_tvalid/o_s_tready  | command beat, 128b + 3b user
//  m        | out       | o_m_tvalid/i_m_tready  | result beat, 152b + 3b user
//  cfg      | in        | i_cfg_valid/o_cfg_ready| track_width, 20b
//
//  One beat enters per cycle while the skid stage is empty; each result runs
//  through the three 32-stage dividers (one quotient bit per stage).
//  Reset clears all valid bits and loads track_width with 128 mm.
//  A downstream stall freezes the whole pipeline once the skid stage fills;
//  nothing is lost or repeated.
// ----------------------------------------------------------------------------
module move_shape_decompose (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // left_speed, right_speed, forward_speed, turn_rate, stop_amount
    input  logic [127:0] i_s_tdata,
    // move_kind, body_frame
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // unit_left, unit_right, cruise_speed, duration, travel_left, travel_right
    output logic [151:0] o_m_tdata,
    // valid_res, time_budget, distance_target
    output logic [2:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [19:0]  i_cfg_data
);

    localparam int SpdW  = msd_pkg::SpdW;
    localparam int NW    = msd_pkg::DivNW;
    localparam int DW    = msd_pkg::DivDW;
    localparam int QW    = msd_pkg::DivQW;
    localparam int Lat   = msd_pkg::DivLat;

    logic [msd_pkg::TrackW-1:0] r_track;
    logic                       w_en;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= 20'd32768;
        end else if (i_cfg_valid) begin
            r_track <= i_cfg_data;
        end
    end

    // ---------------- stage 1: capture, body turn product ----------------
    logic                   r1_v;
    msd_pkg::t_kind         r1_kind;
    logic                   r1_body;
    logic signed [SpdW-1:0] r1_l, r1_r, r1_f;
    logic signed [31:0]     r1_amt;
    logic signed [44:0]     r1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_kind <= msd_pkg::t_kind'(i_s_tuser[1:0]);
            r1_body <= i_s_tuser[2];
            r1_l    <= $signed(i_s_tdata[23:0]);
            r1_r    <= $signed(i_s_tdata[47:24]);
            r1_f    <= $signed(i_s_tdata[71:48]);
            r1_amt  <= $signed(i_s_tdata[127:96]);
            r1_prod <= $signed({1'b0, r_track}) * $signed(i_s_tdata[95:72]);
        end
    end

    // ---------------- stage 2: wheel speeds ----------------
    logic [44:0]        w_pm;
    logic [45:0]        w_hs;
    logic [28:0]        w_hq;
    logic signed [29:0] w_half, w_vl, w_vr;
    logic               w_ovf;

    assign w_pm   = r1_prod[44] ? 45'(-r1_prod) : r1_prod;
    assign w_hs   = {1'b0, w_pm} + 46'd65536;
    assign w_hq   = w_hs[45:17];
    assign w_half = r1_prod[44] ? -$signed({1'b0, w_hq}) : $signed({1'b0, w_hq});
    assign w_vl   = 30'(r1_f) - w_half;
    assign w_vr   = 30'(r1_f) + w_half;
    // out of range when the bits above bit 23 are not a pure sign extension
    assign w_ovf  = (w_vl[29:23] != {7{w_vl[23]}}) || (w_vr[29:23] != {7{w_vr[23]}});

    logic                   r2_v, r2_bad;
    msd_pkg::t_kind         r2_kind;
    logic signed [SpdW-1:0] r2_vl, r2_vr;
    logic [31:0]            r2_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_kind <= r1_kind;
            r2_vl   <= r1_body ? w_vl[23:0] : r1_l;
            r2_vr   <= r1_body ? w_vr[23:0] : r1_r;
            r2_bad  <= (r1_kind == msd_pkg::KIND_STOP) || (r_track == '0)
                       || (r1_body && w_ovf);
            r2_thr  <= r1_amt[31] ? 32'(-r1_amt) : r1_amt;
        end
    end

    // ---------------- stage 3: magnitudes, peak, divisors ----------------
    logic [SpdW-1:0]    w_ml, w_mr, w_peak;
    logic signed [24:0] w_sum, w_dif;
    logic [24:0]        w_msum, w_mdif;

    assign w_ml   = r2_vl[23] ? 24'(-r2_vl) : r2_vl;
    assign w_mr   = r2_vr[23] ? 24'(-r2_vr) : r2_vr;
    assign w_peak = (w_ml > w_mr) ? w_ml : w_mr;
    assign w_sum  = 25'(r2_vl) + 25'(r2_vr);
    assign w_dif  = 25'(r2_vr) - 25'(r2_vl);
    assign w_msum = w_sum[24] ? 25'(-w_sum) : w_sum;
    assign w_mdif = w_dif[24] ? 25'(-w_dif) : w_dif;

    logic               r3_v;
    msd_pkg::t_side     r3_side;
    logic [SpdW-1:0]    r3_ml, r3_mr;
    logic [24:0]        r3_msum, r3_mdif;
    logic [31:0]        r3_thr;
    logic [NW-1:0]      r3_pang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side.bad      <= r2_bad || (w_peak == '0)
                                || ((r2_kind == msd_pkg::KIND_DIST) && (w_msum == '0))
                                || ((r2_kind == msd_pkg::KIND_ANGLE) && (w_mdif == '0));
            r3_side.kind     <= r2_kind;
            r3_side.vl       <= r2_vl;
            r3_side.vr       <= r2_vr;
            r3_side.peak     <= w_peak;
            r3_side.dom_left <= w_ml >= w_mr;
            r3_ml            <= w_ml;
            r3_mr            <= w_mr;
            r3_msum          <= w_msum;
            r3_mdif          <= w_mdif;
            r3_thr           <= r2_thr;
            r3_pang          <= r2_thr * r_track;
        end
    end

    // ---------------- dividers ----------------
    logic [NW-1:0] w_dn;
    logic [DW-1:0] w_dd;
    logic [QW-1:0] w_ql, w_qr, w_qd;

    always_comb begin
        case (r3_side.kind)
            msd_pkg::KIND_TIME: begin
                w_dn = NW'(r3_thr);
                w_dd = msd_pkg::MS_PER_S;
            end
            msd_pkg::KIND_DIST: begin
                w_dn = NW'({r3_thr, 9'd0});
                w_dd = r3_msum;
            end
            msd_pkg::KIND_ANGLE: begin
                w_dn = r3_pang;
                w_dd = r3_mdif;
            end
            default: begin
                w_dn = '0;
                w_dd = msd_pkg::MS_PER_S;
            end
        endcase
    end

    msd_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_l (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (NW'({r3_ml, 14'd0})),
        .i_den (DW'(r3_side.peak)),
        .o_quo (w_ql)
    );

    msd_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (NW'({r3_mr, 14'd0})),
        .i_den (DW'(r3_side.peak)),
        .o_quo (w_qr)
    );

    msd_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_d (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_dn),
        .i_den (w_dd),
        .o_quo (w_qd)
    );

    // hold control alongside the dividers
    msd_pkg::t_side r_dl [0:Lat-1];
    logic           r_dv [0:Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Lat; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv[0] <= r3_v;
            for (int i = 1; i < Lat; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= r3_side;
            for (int i = 1; i < Lat; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    // ---------------- post 1: unit speeds, travel products ----------------
    msd_pkg::t_side w_s;
    logic [15:0]    w_ul, w_ur;

    assign w_s  = r_dl[Lat-1];
    // snap the dominant wheel to exactly one
    assign w_ul = w_s.dom_left ? (w_s.vl[23] ? -msd_pkg::UNIT_ONE : msd_pkg::UNIT_ONE)
                               : (w_s.vl[23] ? -w_ql[15:0] : w_ql[15:0]);
    assign w_ur = !w_s.dom_left ? (w_s.vr[23] ? -msd_pkg::UNIT_ONE : msd_pkg::UNIT_ONE)
                                : (w_s.vr[23] ? -w_qr[15:0] : w_qr[15:0]);

    logic               r4_v, r4_bad;
    msd_pkg::t_kind     r4_kind;
    logic [15:0]        r4_ul, r4_ur;
    logic [SpdW-1:0]    r4_peak;
    logic [QW-1:0]      r4_dur;
    logic signed [56:0] r4_pl, r4_pr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r_dv[Lat-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_bad  <= w_s.bad || (w_qd == '0);
            r4_kind <= w_s.kind;
            r4_ul   <= w_ul;
            r4_ur   <= w_ur;
            r4_peak <= w_s.peak;
            r4_dur  <= w_qd;
            r4_pl   <= w_s.vl * $signed({1'b0, w_qd});
            r4_pr   <= w_s.vr * $signed({1'b0, w_qd});
        end
    end

    // ---------------- post 2: round, saturate, pack ----------------
    function automatic logic [31:0] f_trav(input logic signed [56:0] p);
        logic [56:0] m;
        logic [57:0] s;
        logic [41:0] q;
        logic [41:0] nq;
        m  = p[56] ? 57'(-p) : p;
        s  = {1'b0, m} + 58'd32768;
        q  = s[57:16];
        nq = -q;
        if (p[56]) begin
            f_trav = (q > 42'h0_8000_0000) ? 32'h8000_0000 : nq[31:0];
        end else begin
            f_trav = (q > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
    endfunction

    msd_pkg::t_res w_res;
    logic          w_tm;

    always_comb begin
        w_tm  = r4_kind == msd_pkg::KIND_TIME;
        w_res = '0;
        if (!r4_bad) begin
            w_res.valid_res       = 1'b1;
            w_res.time_budget     = w_tm;
            w_res.distance_target = !w_tm;
            w_res.unit_left       = r4_ul;
            w_res.unit_right      = r4_ur;
            w_res.cruise_speed    = r4_peak;
            w_res.duration        = r4_dur;
            w_res.travel_left     = w_tm ? '0 : f_trav(r4_pl);
            w_res.travel_right    = w_tm ? '0 : f_trav(r4_pr);
        end
    end

    logic          r5_v;
    msd_pkg::t_res r5_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_res <= w_res;
        end
    end

    // ---------------- output register and skid ----------------
    msd_pkg::t_res w_out;

    msd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_data  (r5_res),
        .o_ready (w_en),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_tready)
    );

    assign o_s_tready = w_en;
    assign o_m_tdata  = {w_out.travel_right, w_out.travel_left, w_out.duration,
                         w_out.cruise_speed, w_out.unit_right, w_out.unit_left};
    assign o_m_tuser  = {w_out.distance_target, w_out.time_budget, w_out.valid_res};

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata == '0) && (o_m_tuser == '0))
        else $error("invalid result carries nonzero fields");

    a_one_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> (o_m_tuser[1] != o_m_tuser[2]))
        else $error("valid result must be exactly one of time or distance");

    a_dominant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            (o_m_tdata[15:0] == 16'h4000) || (o_m_tdata[15:0] == 16'hC000)
            || (o_m_tdata[31:16] == 16'h4000) || (o_m_tdata[31:16] == 16'hC000))
        else $error("no wheel snapped to unit speed");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en && r5_v |=> r5_v && $stable(r5_res))
        else $error("last stage changed during stall");
`endif

endmodule

// File: dv/tb_move_shape_decompose.sv
// ----------------------------------------------------------------------------
// tb_move_shape_decompose : self-checking bench for the move shape decomposer
// Drives move commands over the slave stream, predicts each result beat with
// a behavioral shaper and compares the master stream field by field.
// ----------------------------------------------------------------------------
module tb_move_shape_decompose;
    timeunit 1ns;
    timeprecision 1ps;

    // one command as the slave stream carries it
    typedef struct {
        msd_pkg::t_kind     kind;
        logic               body;
        logic signed [23:0] vl_in;
        logic signed [23:0] vr_in;
        logic signed [23:0] fwd;
        logic signed [23:0] omega;
        logic signed [31:0] amount;
    } t_cmd;

    // one row of the directed table; chk set means the typed result is used
    typedef struct {
        t_cmd          cmd;
        logic          chk;
        msd_pkg::t_res res;
    } t_row;

    localparam int PIPE_LAT = 39;
    localparam int WDOG_MAX = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [127:0] i_s_tdata = '0;
    logic [2:0]   i_s_tuser = '0;
    logic         i_m_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [19:0]  i_cfg_data = '0;
    logic         o_s_tready, o_m_tvalid, o_cfg_ready;
    logic [151:0] o_m_tdata;
    logic [2:0]   o_m_tuser;

    move_shape_decompose dut (.*);

    always #1 i_clk = ~i_clk;

    logic [19:0]   track_q = 20'd32768;
    msd_pkg::t_res shape_q[$];
    int            n_err = 0;
    int            idle_cyc = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_m = 1'b0;

    // round-to-nearest quotient of magnitudes
    function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic longint rshr(longint x, int s);
        longint unsigned m, q;
        m = (x < 0) ? -x : x;
        q = (m + (64'd1 << (s - 1))) >> s;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] sat32(longint x);
        if (x > 64'sd2147483647) return 32'h7fffffff;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[31:0];
    endfunction

    function automatic longint unsigned absv(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // shape one command into its expected result beat
    function automatic msd_pkg::t_res shape_move(t_cmd c, logic [19:0] tw);
        msd_pkg::t_res r;
        longint vl, vr, half, ul, ur;
        longint unsigned peak, thr, dur, s;
        r = '0;
        if (c.kind == msd_pkg::KIND_STOP || tw == 0) return r;
        if (c.body) begin
            half = rshr(longint'(tw) * longint'(c.omega), 17);
            vl = longint'(c.fwd) - half;
            vr = longint'(c.fwd) + half;
            if (vl > 8388607 || vl < -8388608 || vr > 8388607 || vr < -8388608) return r;
        end else begin
            vl = c.vl_in;
            vr = c.vr_in;
        end
        peak = (absv(vl) > absv(vr)) ? absv(vl) : absv(vr);
        if (peak == 0) return r;
        ul = rdiv(absv(vl) * 16384, peak);
        ur = rdiv(absv(vr) * 16384, peak);
        if (vl < 0) ul = -ul;
        if (vr < 0) ur = -ur;
        // dominant wheel snaps to exactly one
        if (absv(vl) >= absv(vr)) ul = (vl < 0) ? -16384 : 16384;
        else ur = (vr < 0) ? -16384 : 16384;
        thr = absv(longint'(c.amount));
        if (c.kind == msd_pkg::KIND_TIME) begin
            dur = rdiv(thr, 1000);
            if (dur == 0) return r;
        end else begin
            s = (c.kind == msd_pkg::KIND_DIST) ? absv(vl + vr) : absv(vr - vl);
            if (s == 0) return r;
            dur = (c.kind == msd_pkg::KIND_DIST) ? rdiv(thr * 512, s) : rdiv(thr * tw, s);
            if (dur == 0) return r;
            if (dur > 64'hffffffff) dur = 64'hffffffff;
            r.travel_left = sat32(rshr(vl * longint'(dur), 16));
            r.travel_right = sat32(rshr(vr * longint'(dur), 16));
            r.distance_target = 1'b1;
        end
        r.time_budget = (c.kind == msd_pkg::KIND_TIME);
        r.valid_res = 1'b1;
        r.unit_left = ul[15:0];
        r.unit_right = ur[15:0];
        r.cruise_speed = peak[23:0];
        r.duration = dur[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        n_err++;
    endtask

    // sample the master side: compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        msd_pkg::t_res got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '0;
            {got.travel_right, got.travel_left, got.duration, got.cruise_speed,
             got.unit_right, got.unit_left} = o_m_tdata;
            {got.distance_target, got.time_budget, got.valid_res} = o_m_tuser;
            if (shape_q.size() == 0) begin
                report_mismatch("unexpected beat", o_m_tdata[63:0], 64'd0);
            end else begin
                want = shape_q.pop_front();
                if (got.valid_res !== want.valid_res)
                    report_mismatch("valid_res", 64'(got.valid_res), 64'(want.valid_res));
                if (got.unit_left !== want.unit_left)
                    report_mismatch("unit_left", 64'(got.unit_left), 64'(want.unit_left));
                if (got.unit_right !== want.unit_right)
                    report_mismatch("unit_right", 64'(got.unit_right),
                                    64'(want.unit_right));
                if (got.cruise_speed !== want.cruise_speed)
                    report_mismatch("cruise_speed", 64'(got.cruise_speed),
                                    64'(want.cruise_speed));
                if (got.duration !== want.duration)
                    report_mismatch("duration", 64'(got.duration), 64'(want.duration));
                if (got.travel_left !== want.travel_left)
                    report_mismatch("travel_left", 64'(got.travel_left),
                                    64'(want.travel_left));
                if (got.travel_right !== want.travel_right)
                    report_mismatch("travel_right", 64'(got.travel_right),
                                    64'(want.travel_right));
                if (got.time_budget !== want.time_budget)
                    report_mismatch("time_budget", 64'(got.time_budget),
                                    64'(want.time_budget));
                if (got.distance_target !== want.distance_target)
                    report_mismatch("distance_target", 64'(got.distance_target),
                                    64'(want.distance_target));
            end
        end
    end

    // receiver stalls, redrawn each falling edge
    always @(negedge i_clk) begin
        i_m_tready <= !hold_m && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles without any accepted beat on any channel
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WDOG_MAX) begin
            $display("move_shape_decompose regression: fail");
            $finish;
        end
    end

    // push one command beat; a random gap may be taken first
    task automatic send_cmd(t_cmd c, logic chk, msd_pkg::t_res typed);
        msd_pkg::t_res want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tdata <= {c.amount, c.omega, c.fwd, c.vr_in, c.vl_in};
        i_s_tuser <= {c.body, c.kind};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        want = shape_move(c, track_q);
        if (chk && want !== typed) begin
            report_mismatch("typed row", 64'({want.valid_res, want.duration}),
                            64'({typed.valid_res, typed.duration}));
            want = typed;
        end
        shape_q.push_back(want);
        @(negedge i_clk);
    endtask

    // let the pipeline drain, then sit out the latency
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (shape_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 5) @(negedge i_clk);
    endtask

    task automatic write_track(logic [19:0] tw);
        i_cfg_data <= tw;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        track_q = tw;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cmd mk(msd_pkg::t_kind k, int b, int l, int r, int f, int w,
                                int a);
        t_cmd c;
        c.kind = k; c.body = b[0]; c.vl_in = 24'(l); c.vr_in = 24'(r);
        c.fwd = 24'(f); c.omega = 24'(w); c.amount = a;
        return c;
    endfunction

    // random command: mostly plausible speeds, some full-range noise
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int sel;
        c.kind = msd_pkg::t_kind'($urandom_range(3));
        c.body = 1'($urandom_range(1));
        sel = $urandom_range(9);
        c.vl_in = (sel < 7) ? 24'($urandom_range(40000) - 20000) : 24'($urandom);
        c.vr_in = (sel < 7) ? 24'($urandom_range(40000) - 20000) : 24'($urandom);
        if ($urandom_range(15) == 0) c.vr_in = c.vl_in;
        if ($urandom_range(15) == 0) c.vr_in = -c.vl_in;
        c.fwd = (sel < 7) ? 24'($urandom_range(40000) - 20000) : 24'($urandom);
        c.omega = (sel < 7) ? 24'($urandom_range(400000) - 200000) : 24'($urandom);
        if ($urandom_range(7) == 0) c.omega = '0;
        c.amount = (sel < 8) ? 32'($urandom_range(4000000) - 2000000) : $urandom;
        return c;
    endfunction

    t_row dir_tab[$];

    initial begin
        t_row          row;
        msd_pkg::t_res z;
        t_cmd          c;
        int            ph;
        z = '0;
        // stop kind, standstill, pivot on distance, straight on angle: all invalid
        dir_tab.push_back('{mk(msd_pkg::KIND_STOP, 0, 2560, 2560, 0, 0, 65536000), 1'b1, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_TIME, 0, 0, 0, 0, 0, 65536000), 1'b1, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_DIST, 0, 2560, -2560, 0, 0, 65536), 1'b1, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_ANGLE, 0, 2560, 2560, 0, 0, 65536), 1'b1, z});
        // zero duration on a time move
        dir_tab.push_back('{mk(msd_pkg::KIND_TIME, 0, 2560, 2560, 0, 0, 499), 1'b1, z});
        // time move 1000 ms at 10 mm/s straight
        row = '{mk(msd_pkg::KIND_TIME, 0, 2560, 2560, 0, 0, 65536000), 1'b1, z};
        row.res.valid_res = 1'b1; row.res.time_budget = 1'b1;
        row.res.unit_left = msd_pkg::UNIT_ONE; row.res.unit_right = msd_pkg::UNIT_ONE;
        row.res.cruise_speed = 24'd2560; row.res.duration = 32'd65536;
        dir_tab.push_back(row);
        // speed extremes, wheel speed overflow, long duration, large travel
        dir_tab.push_back('{mk(msd_pkg::KIND_DIST, 0, 8388607, -8388608, 0, 0,
                               32'h7fffffff), 1'b0, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_DIST, 0, 1, 0, 0, 0, 32'h80000000), 1'b0, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_ANGLE, 0, -8388608, 1, 0, 0, -65536), 1'b0, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_TIME, 0, -8388608, 8388607, 0, 0,
                               32'h80000000), 1'b0, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_DIST, 1, 0, 0, 8388607, 8388607, 65536),
                           1'b1, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_ANGLE, 1, 0, 0, -8388608, -8388608, 65536),
                           1'b1, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_ANGLE, 1, 0, 0, 2560, 65536, 205887), 1'b0, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_DIST, 1, 0, 0, -2560, -65536, 65536), 1'b0, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_ANGLE, 0, 3, -7, 0, 0, 1), 1'b0, z});
        dir_tab.push_back('{mk(msd_pkg::KIND_DIST, 0, -3, -7, 0, 0, 100), 1'b0, z});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 24; recv_idle_pct = 47;
        foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].chk, dir_tab[i].res);
        drain();
        // zero track: every kind invalid
        write_track(20'd0);
        for (int k = 0; k < 4; k++)
            send_cmd(mk(msd_pkg::t_kind'(k), 0, 2560, 1280, 0, 0, 65536000), 1'b1, z);
        drain();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_track(20'd1);
                1: write_track(20'hfffff);
                2: write_track(20'd32768);
                default: write_track(20'($urandom_range(20'hfffff, 1)));
            endcase
            send_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 47 : 0;
            recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 24 : 0;
            for (int n = 0; n < 205; n++) begin
                c = rand_cmd();
                send_cmd(c, 1'b0, z);
                // pause once until every expected beat is back
                if (ph == 3 && n == 100) begin
                    i_s_tvalid <= 1'b0;
                    while (shape_q.size() != 0) @(negedge i_clk);
                end
            end
            drain();
        end

        if (n_err == 0)
            $display("move_shape_decompose regression: pass");
        else
            $display("move_shape_decompose regression: fail");
        $finish;
    end
endmodule
